FILE: rtl/core/bqsp_pkg.sv
// Shared types, codes and helpers for the bucket-queue shortest path block.
`timescale 1ns / 1ps
package bqsp_pkg;

    localparam int IDX_W  = 10;
    localparam int LEN_W  = 24;
    localparam int DIST_W = 32;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam int DEF_NUM_BINS     = 512;

    typedef enum logic [1:0] {
        ACT_LOAD_SEG  = 2'd0,
        ACT_LOAD_EDGE = 2'd1,
        ACT_RUN       = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    localparam logic RES_RUN  = 1'b0;
    localparam logic RES_READ = 1'b1;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_INIT,
        S_SRC_LEN,
        S_SRC_DIV,
        S_PUSH_RD,
        S_PUSH_WR,
        S_SCAN,
        S_SCAN_CHK,
        S_POP,
        S_HNODE,
        S_HSEG,
        S_EDGE,
        S_EDGE_RD,
        S_NNODE,
        S_NSEG,
        S_NDIV,
        S_TGT,
        S_PATH,
        S_PATH_CHK,
        S_SRC_RD,
        S_SRC_MARK,
        S_FINISH
    } t_state;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_SAT : s[DIST_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bqsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module bqsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bqsp_div.sv
// Bucket offset unit: round((NUM_BINS-1)*len/max), one quotient bit per cycle.
`timescale 1ns / 1ps
module bqsp_div #(
    parameter int NUM_BINS = bqsp_pkg::DEF_NUM_BINS,
    localparam int BW = $clog2(NUM_BINS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bqsp_pkg::LEN_W-1:0] i_len,
    input  logic [bqsp_pkg::LEN_W-1:0] i_max,
    output logic                      o_done,
    output logic [BW-1:0]             o_quot
);
    import bqsp_pkg::*;

    localparam int RW = LEN_W + BW + 2;
    localparam int CW = $clog2(BW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_den, n_den;
    logic [BW-1:0] r_quot, n_quot;
    logic          w_bit;

    assign w_bit = (r_rem >= r_den);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_quot = '0;
            if (i_max == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                // numerator 2*(N-1)*len + max, divisor 2*max aligned to the top bit
                n_rem  = RW'(i_len) * RW'(2 * (NUM_BINS - 1)) + RW'(i_max);
                n_den  = RW'(i_max) << BW;
                n_cnt  = CW'(BW);
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (w_bit) begin
                n_rem = r_rem - r_den;
            end
            n_quot = BW'({r_quot, w_bit});
            n_den  = r_den >> 1;
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/bucket_queue_shortest_path_top.sv
// Top level: segment graph loader, bucket-queue search sequencer and path numbering.
`timescale 1ns / 1ps
// Segment and neighbor loads are taken one per cycle while the output register is free; a read
// also needs the output register free. A run first sweeps the per-segment and bucket memories,
// one entry a cycle, then searches: buckets are scanned, entries popped and neighbors checked,
// and the offset divider runs for every newly reached neighbor; path numbering then follows the
// parent links hop by hop. The segment, edge, node, bucket and link tables live in RAMs with one
// write port and one read port each. After reset the same sweep runs before the first word
// is accepted; configuration writes are taken at any time.
module bucket_queue_shortest_path_top #(
    parameter int MAX_SEGMENTS = bqsp_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_EDGES    = bqsp_pkg::DEF_MAX_EDGES,
    parameter int NUM_BINS     = bqsp_pkg::DEF_NUM_BINS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bqsp_pkg::IDX_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [bqsp_pkg::IDX_W-1:0]  i_seg_index,
    input  logic [bqsp_pkg::LEN_W-1:0]  i_seg_length,
    input  logic [bqsp_pkg::IDX_W-1:0]  i_neighbor_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_result_kind,
    output logic [bqsp_pkg::IDX_W-1:0]  o_seg_index_res,
    output logic                        o_on_path,
    output logic [bqsp_pkg::IDX_W-1:0]  o_path_order,
    output logic [bqsp_pkg::DIST_W-1:0] o_distance_half,
    output logic                        o_found,
    output logic [bqsp_pkg::IDX_W-1:0]  o_path_hops
);
    import bqsp_pkg::*;

    localparam int SW    = $clog2(MAX_SEGMENTS);
    localparam int EW    = $clog2(MAX_EDGES + 1);
    localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PAW   = $clog2(MAX_EDGES + 1);
    localparam int PCW   = $clog2(MAX_EDGES + 2);
    localparam int BW    = $clog2(NUM_BINS);
    localparam int CLR_N = (MAX_SEGMENTS > NUM_BINS) ? MAX_SEGMENTS : NUM_BINS;
    localparam int CLW   = $clog2(CLR_N);

    typedef struct packed {
        logic [DIST_W-1:0] seen;
        logic [DIST_W-1:0] trail;
        logic [DIST_W-1:0] rec;
        logic              done;
        logic              pval;
        logic [SW-1:0]     parent;
        logic              oval;
        logic [SW:0]       order;
    } t_node;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [EW-1:0]    start;
        logic [EW-1:0]    cnt;
    } t_seg;

    typedef struct packed {
        logic           hval;
        logic [PAW-1:0] hidx;
    } t_head;

    typedef struct packed {
        logic [SW-1:0]  seg;
        logic           nval;
        logic [PAW-1:0] next;
    } t_link;

    // memory ports
    logic           w_seg_we, w_node_we, w_edge_we, w_head_we, w_link_we;
    logic [SW-1:0]  w_seg_waddr, w_seg_raddr, w_node_waddr, w_node_raddr;
    logic [EAW-1:0] w_edge_waddr, w_edge_raddr;
    logic [BW-1:0]  w_head_waddr, w_head_raddr;
    logic [PAW-1:0] w_link_waddr, w_link_raddr;
    t_seg           w_seg_wdata, w_seg_rdata;
    t_node          w_node_wdata, w_node_rdata;
    logic [SW-1:0]  w_edge_wdata, w_edge_rdata;
    t_head          w_head_wdata, w_head_rdata;
    t_link          w_link_wdata, w_link_rdata;

    logic             w_div_start, w_div_done;
    logic [LEN_W-1:0] w_div_len;
    logic [BW-1:0]    w_div_quot;

    t_state r_state, n_state;
    logic             r_run, n_run;
    logic [CLW-1:0]   r_clr, n_clr;
    logic [IDX_W-1:0] r_src, r_tgt;
    logic [LEN_W-1:0] r_max, n_max;
    logic [EW-1:0]    r_fill, n_fill;
    logic             r_cur_valid, n_cur_valid;
    logic [SW-1:0]    r_cur_seg, n_cur_seg;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic [EW-1:0]    r_cur_start, n_cur_start;
    logic [EW-1:0]    r_cur_cnt, n_cur_cnt;
    logic [IDX_W-1:0] r_rd_seg, n_rd_seg;
    logic             r_rd_ok, n_rd_ok;
    logic [SW:0]      r_count, n_count;
    logic             r_found, n_found;
    logic [BW-1:0]    r_bin, n_bin;
    logic [DIST_W-1:0] r_depth, n_depth;
    logic [PCW-1:0]   r_open, n_open;
    logic [PCW-1:0]   r_pool, n_pool;
    logic [SW-1:0]    r_h, n_h;
    logic [DIST_W-1:0] r_htrail, n_htrail;
    logic [EW-1:0]    r_estart, n_estart;
    logic [EW-1:0]    r_ecnt, n_ecnt;
    logic [EW-1:0]    r_k, n_k;
    logic [SW-1:0]    r_n, n_n;
    t_node            r_nnode, n_nnode;
    logic [SW-1:0]    r_pseg, n_pseg;
    logic [BW-1:0]    r_pbin, n_pbin;
    logic             r_ret_edge, n_ret_edge;
    logic [SW-1:0]    r_pnode, n_pnode;

    logic              r_out_valid;
    logic              w_out_load;
    logic              r_out_kind, n_out_kind;
    logic [IDX_W-1:0]  r_out_seg, n_out_seg;
    logic              r_out_on, n_out_on;
    logic [IDX_W-1:0]  r_out_order, n_out_order;
    logic [DIST_W-1:0] r_out_dist, n_out_dist;
    logic              r_out_found, n_out_found;
    logic [IDX_W-1:0]  r_out_hops, n_out_hops;

    logic          w_accept;
    logic [31:0]   w_seg_wide, w_nb_wide, w_src_wide, w_tgt_wide, w_clr_wide;
    logic          w_seg_ok, w_nb_ok, w_src_ok, w_tgt_ok;
    logic [SW-1:0] w_seg_idx, w_nb_idx, w_src_idx, w_tgt_idx;
    logic [BW:0]   w_bin_inc, w_bin_add;
    logic [BW-1:0] w_bin_next, w_bin_push;
    logic [31:0]   w_count_wide, w_order_wide;
    logic          w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;

    assign w_seg_wide = 32'(i_seg_index);
    assign w_nb_wide  = 32'(i_neighbor_index);
    assign w_src_wide = 32'(r_src);
    assign w_tgt_wide = 32'(r_tgt);
    assign w_clr_wide = 32'(r_clr);
    assign w_seg_ok   = w_seg_wide < MAX_SEGMENTS;
    assign w_nb_ok    = w_nb_wide < MAX_SEGMENTS;
    assign w_src_ok   = w_src_wide < MAX_SEGMENTS;
    assign w_tgt_ok   = w_tgt_wide < MAX_SEGMENTS;
    assign w_seg_idx  = w_seg_wide[SW-1:0];
    assign w_nb_idx   = w_nb_wide[SW-1:0];
    assign w_src_idx  = w_src_wide[SW-1:0];
    assign w_tgt_idx  = w_tgt_wide[SW-1:0];

    // circular bucket index arithmetic
    assign w_bin_inc  = {1'b0, r_bin} + (BW + 1)'(1);
    assign w_bin_next = (32'(w_bin_inc) >= NUM_BINS) ? BW'(32'(w_bin_inc) - NUM_BINS)
                                                      : w_bin_inc[BW-1:0];
    assign w_bin_add  = {1'b0, r_bin} + {1'b0, w_div_quot};
    assign w_bin_push = (32'(w_bin_add) >= NUM_BINS) ? BW'(32'(w_bin_add) - NUM_BINS)
                                                      : w_bin_add[BW-1:0];

    assign w_count_wide = 32'(r_count);
    assign w_order_wide = 32'(r_count - w_node_rdata.order);

    bqsp_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk(i_clk), .i_we(w_seg_we), .i_waddr(w_seg_waddr), .i_wdata(w_seg_wdata),
        .i_raddr(w_seg_raddr), .o_rdata(w_seg_rdata)
    );

    bqsp_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(w_edge_we), .i_waddr(w_edge_waddr), .i_wdata(w_edge_wdata),
        .i_raddr(w_edge_raddr), .o_rdata(w_edge_rdata)
    );

    bqsp_ram #(.WIDTH($bits(t_node)), .DEPTH(MAX_SEGMENTS)) u_node_ram (
        .i_clk(i_clk), .i_we(w_node_we), .i_waddr(w_node_waddr), .i_wdata(w_node_wdata),
        .i_raddr(w_node_raddr), .o_rdata(w_node_rdata)
    );

    bqsp_ram #(.WIDTH($bits(t_head)), .DEPTH(NUM_BINS)) u_head_ram (
        .i_clk(i_clk), .i_we(w_head_we), .i_waddr(w_head_waddr), .i_wdata(w_head_wdata),
        .i_raddr(w_head_raddr), .o_rdata(w_head_rdata)
    );

    bqsp_ram #(.WIDTH($bits(t_link)), .DEPTH(MAX_EDGES + 1)) u_link_ram (
        .i_clk(i_clk), .i_we(w_link_we), .i_waddr(w_link_waddr), .i_wdata(w_link_wdata),
        .i_raddr(w_link_raddr), .o_rdata(w_link_rdata)
    );

    bqsp_div #(.NUM_BINS(NUM_BINS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_len(w_div_len),
        .i_max(r_max), .o_done(w_div_done), .o_quot(w_div_quot)
    );

    always_comb begin : next_state
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLW'(CLR_N - 1)) begin
                    n_state = r_run ? S_INIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (t_action'(i_action))
                        ACT_RUN:  n_state = S_CLEAR;
                        ACT_READ: n_state = S_READ;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:     n_state = S_IDLE;
            S_INIT:     n_state = w_src_ok ? S_SRC_LEN : S_FINISH;
            S_SRC_LEN:  n_state = S_SRC_DIV;
            S_SRC_DIV: begin
                if (w_div_done) begin
                    n_state = S_PUSH_RD;
                end
            end
            S_PUSH_RD: begin
                if (r_pool == PCW'(MAX_EDGES + 1)) begin
                    n_state = r_ret_edge ? S_TGT : S_SCAN;
                end else begin
                    n_state = S_PUSH_WR;
                end
            end
            S_PUSH_WR:  n_state = r_ret_edge ? S_TGT : S_SCAN;
            S_SCAN:     n_state = (r_open == '0 || r_found) ? S_PATH : S_SCAN_CHK;
            S_SCAN_CHK: n_state = w_head_rdata.hval ? S_POP : S_SCAN;
            S_POP:      n_state = S_HNODE;
            S_HNODE:    n_state = w_node_rdata.done ? S_SCAN : S_HSEG;
            S_HSEG:     n_state = S_EDGE;
            S_EDGE:     n_state = (r_k == r_ecnt) ? S_SCAN : S_EDGE_RD;
            S_EDGE_RD:  n_state = S_NNODE;
            S_NNODE:    n_state = (w_node_rdata.seen > r_depth) ? S_NSEG : S_TGT;
            S_NSEG:     n_state = S_NDIV;
            S_NDIV: begin
                if (w_div_done) begin
                    n_state = S_PUSH_RD;
                end
            end
            S_TGT:      n_state = (w_tgt_ok && r_n == w_tgt_idx) ? S_SCAN : S_EDGE;
            S_PATH:     n_state = w_tgt_ok ? S_PATH_CHK : S_SRC_RD;
            S_PATH_CHK: begin
                if (w_node_rdata.pval && w_count_wide < MAX_SEGMENTS) begin
                    n_state = S_PATH;
                end else begin
                    n_state = S_SRC_RD;
                end
            end
            S_SRC_RD:   n_state = S_SRC_MARK;
            S_SRC_MARK: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin : outputs
        w_seg_we     = 1'b0;
        w_seg_waddr  = r_cur_seg;
        w_seg_wdata  = '0;
        w_seg_raddr  = r_h;
        w_edge_we    = 1'b0;
        w_edge_waddr = r_fill[EAW-1:0];
        w_edge_wdata = w_nb_idx;
        w_edge_raddr = EAW'(r_estart + r_k);
        w_node_we    = 1'b0;
        w_node_waddr = r_n;
        w_node_wdata = '0;
        w_node_raddr = r_n;
        w_head_we    = 1'b0;
        w_head_waddr = r_bin;
        w_head_wdata = '0;
        w_head_raddr = r_bin;
        w_link_we    = 1'b0;
        w_link_waddr = r_pool[PAW-1:0];
        w_link_wdata = '0;
        w_link_raddr = w_head_rdata.hidx;
        w_div_start  = 1'b0;
        w_div_len    = w_seg_rdata.len;
        w_out_load   = 1'b0;

        n_run       = r_run;
        n_clr       = r_clr;
        n_max       = r_max;
        n_fill      = r_fill;
        n_cur_valid = r_cur_valid;
        n_cur_seg   = r_cur_seg;
        n_cur_len   = r_cur_len;
        n_cur_start = r_cur_start;
        n_cur_cnt   = r_cur_cnt;
        n_rd_seg    = r_rd_seg;
        n_rd_ok     = r_rd_ok;
        n_count     = r_count;
        n_found     = r_found;
        n_bin       = r_bin;
        n_depth     = r_depth;
        n_open      = r_open;
        n_pool      = r_pool;
        n_h         = r_h;
        n_htrail    = r_htrail;
        n_estart    = r_estart;
        n_ecnt      = r_ecnt;
        n_k         = r_k;
        n_n         = r_n;
        n_nnode     = r_nnode;
        n_pseg      = r_pseg;
        n_pbin      = r_pbin;
        n_ret_edge  = r_ret_edge;
        n_pnode     = r_pnode;
        n_out_kind  = r_out_kind;
        n_out_seg   = r_out_seg;
        n_out_on    = r_out_on;
        n_out_order = r_out_order;
        n_out_dist  = r_out_dist;
        n_out_found = r_out_found;
        n_out_hops  = r_out_hops;

        case (r_state)
            S_CLEAR: begin
                w_node_we         = (w_clr_wide < MAX_SEGMENTS);
                w_node_waddr      = w_clr_wide[SW-1:0];
                w_node_wdata.seen = DIST_SAT;
                w_head_we         = (w_clr_wide < NUM_BINS);
                w_head_waddr      = w_clr_wide[BW-1:0];
                n_clr             = r_clr + CLW'(1);
            end
            S_IDLE: begin
                w_node_raddr = w_seg_idx;
                n_rd_seg     = i_seg_index;
                n_rd_ok      = w_seg_ok;
                n_clr        = '0;
                if (w_accept) begin
                    case (t_action'(i_action))
                        ACT_LOAD_SEG: begin
                            n_cur_valid = w_seg_ok;
                            if (w_seg_ok) begin
                                w_seg_we    = 1'b1;
                                w_seg_waddr = w_seg_idx;
                                w_seg_wdata = '{len: i_seg_length, start: r_fill, cnt: '0};
                                n_cur_seg   = w_seg_idx;
                                n_cur_len   = i_seg_length;
                                n_cur_start = r_fill;
                                n_cur_cnt   = '0;
                                if (i_seg_length > r_max) begin
                                    n_max = i_seg_length;
                                end
                            end
                        end
                        ACT_LOAD_EDGE: begin
                            if (r_cur_valid && w_nb_ok && r_fill < EW'(MAX_EDGES)) begin
                                w_edge_we   = 1'b1;
                                w_seg_we    = 1'b1;
                                w_seg_wdata = '{len: r_cur_len, start: r_cur_start,
                                                cnt: r_cur_cnt + EW'(1)};
                                n_cur_cnt   = r_cur_cnt + EW'(1);
                                n_fill      = r_fill + EW'(1);
                            end
                        end
                        ACT_RUN: begin
                            n_run = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                w_out_load  = 1'b1;
                n_out_kind  = RES_READ;
                n_out_seg   = r_rd_seg;
                n_out_found = 1'b0;
                n_out_hops  = '0;
                n_out_on    = r_rd_ok && w_node_rdata.oval;
                n_out_order = (r_rd_ok && w_node_rdata.oval) ? w_order_wide[IDX_W-1:0] : '0;
                n_out_dist  = (r_rd_ok && w_node_rdata.oval) ? w_node_rdata.rec : '0;
            end
            S_INIT: begin
                n_count     = '0;
                n_found     = 1'b0;
                n_bin       = '0;
                n_depth     = '0;
                n_open      = '0;
                n_pool      = '0;
                w_seg_raddr = w_src_idx;
            end
            S_SRC_LEN: begin
                w_node_we          = 1'b1;
                w_node_waddr       = w_src_idx;
                w_node_wdata.seen  = '0;
                w_node_wdata.trail = DIST_W'(w_seg_rdata.len);
                w_node_wdata.rec   = '0;
                w_div_start        = 1'b1;
                n_pseg             = w_src_idx;
                n_ret_edge         = 1'b0;
            end
            S_SRC_DIV: begin
                n_pbin = w_div_quot;
            end
            S_PUSH_RD: begin
                w_head_raddr = r_pbin;
            end
            S_PUSH_WR: begin
                w_link_we    = 1'b1;
                w_link_wdata = '{seg: r_pseg, nval: w_head_rdata.hval,
                                 next: w_head_rdata.hidx};
                w_head_we    = 1'b1;
                w_head_waddr = r_pbin;
                w_head_wdata = '{hval: 1'b1, hidx: r_pool[PAW-1:0]};
                n_pool       = r_pool + PCW'(1);
                n_open       = r_open + PCW'(1);
            end
            S_SCAN: begin
                n_pnode = w_tgt_idx;
            end
            S_SCAN_CHK: begin
                if (!w_head_rdata.hval) begin
                    n_bin   = w_bin_next;
                    n_depth = r_depth + DIST_W'(1);
                end
            end
            S_POP: begin
                w_head_we    = 1'b1;
                w_head_wdata = '{hval: w_link_rdata.nval, hidx: w_link_rdata.next};
                n_open       = r_open - PCW'(1);
                n_h          = w_link_rdata.seg;
                w_node_raddr = w_link_rdata.seg;
            end
            S_HNODE: begin
                if (!w_node_rdata.done) begin
                    w_node_we         = 1'b1;
                    w_node_waddr      = r_h;
                    w_node_wdata      = w_node_rdata;
                    w_node_wdata.done = 1'b1;
                    n_htrail          = w_node_rdata.trail;
                end
            end
            S_HSEG: begin
                n_estart = w_seg_rdata.start;
                n_ecnt   = w_seg_rdata.cnt;
                n_k      = '0;
            end
            S_EDGE_RD: begin
                n_n          = w_edge_rdata;
                w_node_raddr = w_edge_rdata;
            end
            S_NNODE: begin
                n_nnode     = w_node_rdata;
                w_seg_raddr = r_n;
            end
            S_NSEG: begin
                w_node_we           = 1'b1;
                w_node_waddr        = r_n;
                w_node_wdata        = r_nnode;
                w_node_wdata.seen   = r_depth;
                w_node_wdata.trail  = sat_add(r_htrail, DIST_W'({w_seg_rdata.len, 1'b0}));
                w_node_wdata.rec    = sat_add(r_htrail, DIST_W'(w_seg_rdata.len));
                w_node_wdata.parent = r_h;
                w_node_wdata.pval   = 1'b1;
                w_div_start         = 1'b1;
                n_pseg              = r_n;
                n_ret_edge          = 1'b1;
            end
            S_NDIV: begin
                n_pbin = w_bin_push;
            end
            S_TGT: begin
                if (w_tgt_ok && r_n == w_tgt_idx) begin
                    n_found = 1'b1;
                end else begin
                    n_k = r_k + EW'(1);
                end
            end
            S_PATH: begin
                w_node_raddr = r_pnode;
            end
            S_PATH_CHK: begin
                if (w_node_rdata.pval && w_count_wide < MAX_SEGMENTS) begin
                    w_node_we          = 1'b1;
                    w_node_waddr       = r_pnode;
                    w_node_wdata       = w_node_rdata;
                    w_node_wdata.oval  = 1'b1;
                    w_node_wdata.order = r_count;
                    n_count            = r_count + (SW + 1)'(1);
                    n_pnode            = w_node_rdata.parent;
                end
            end
            S_SRC_RD: begin
                w_node_raddr = w_src_idx;
            end
            S_SRC_MARK: begin
                w_node_we          = 1'b1;
                w_node_waddr       = w_src_idx;
                w_node_wdata       = w_node_rdata;
                w_node_wdata.oval  = 1'b1;
                w_node_wdata.order = r_count;
            end
            S_FINISH: begin
                n_run = 1'b0;
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_kind  = RES_RUN;
                    n_out_seg   = '0;
                    n_out_on    = 1'b0;
                    n_out_order = '0;
                    n_out_dist  = '0;
                    n_out_found = r_found;
                    n_out_hops  = r_found ? w_count_wide[IDX_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_run       <= 1'b0;
            r_clr       <= '0;
            r_src       <= '0;
            r_tgt       <= '0;
            r_max       <= '0;
            r_fill      <= '0;
            r_cur_valid <= 1'b0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_open      <= '0;
            r_pool      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_clr       <= n_clr;
            r_max       <= n_max;
            r_fill      <= n_fill;
            r_cur_valid <= n_cur_valid;
            r_count     <= n_count;
            r_found     <= n_found;
            r_open      <= n_open;
            r_pool      <= n_pool;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SOURCE: r_src <= i_cfg_data;
                    REG_TARGET: r_tgt <= i_cfg_data;
                    default:    r_src <= r_src;
                endcase
            end
        end
        r_cur_seg   <= n_cur_seg;
        r_cur_len   <= n_cur_len;
        r_cur_start <= n_cur_start;
        r_cur_cnt   <= n_cur_cnt;
        r_rd_seg    <= n_rd_seg;
        r_rd_ok     <= n_rd_ok;
        r_bin       <= n_bin;
        r_depth     <= n_depth;
        r_h         <= n_h;
        r_htrail    <= n_htrail;
        r_estart    <= n_estart;
        r_ecnt      <= n_ecnt;
        r_k         <= n_k;
        r_n         <= n_n;
        r_nnode     <= n_nnode;
        r_pseg      <= n_pseg;
        r_pbin      <= n_pbin;
        r_ret_edge  <= n_ret_edge;
        r_pnode     <= n_pnode;
        r_out_kind  <= n_out_kind;
        r_out_seg   <= n_out_seg;
        r_out_on    <= n_out_on;
        r_out_order <= n_out_order;
        r_out_dist  <= n_out_dist;
        r_out_found <= n_out_found;
        r_out_hops  <= n_out_hops;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_seg_index_res = r_out_seg;
    assign o_on_path       = r_out_on;
    assign o_path_order    = r_out_order;
    assign o_distance_half = r_out_dist;
    assign o_found         = r_out_found;
    assign o_path_hops     = r_out_hops;

    a_open_le_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= r_pool)
        else $error("open entry count exceeds pool use");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_RUN) |=> (r_state == S_CLEAR && r_run))
        else $error("run word did not start the clearing sweep");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read answer would overwrite a pending word");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_NDIV || r_state == S_SRC_DIV))
        else $error("offset result arrived outside a wait state");

endmodule
